// ===== src/bkfd_pkg.sv =====
// ----------------------------------------------------------------------------
// bkfd_pkg: shared types and constants of the braille key frame decoder
// Frame byte codes, frame positions, key code table and result encodings.
// ----------------------------------------------------------------------------
package bkfd_pkg;

    localparam int DEFAULT_MAX_FRAME_BYTES = 20;
    localparam int MIN_FRAME_BYTES = 7;
    localparam int POS_W = 5;

    localparam logic [7:0] START_BYTE = 8'h02;
    localparam logic [7:0] ID_BYTE = 8'h4B;
    localparam logic [7:0] END_BYTE = 8'h03;
    localparam logic [7:0] PRESS_RESET = 8'h01;

    // byte positions inside a frame
    localparam logic [POS_W-1:0] POS_HUNT = 5'd0;
    localparam logic [POS_W-1:0] POS_ID = 5'd1;
    localparam logic [POS_W-1:0] POS_KEY_HI = 5'd2;
    localparam logic [POS_W-1:0] POS_KEY_LO = 5'd3;
    localparam logic [POS_W-1:0] POS_LEN_HI = 5'd4;
    localparam logic [POS_W-1:0] POS_LEN_LO = 5'd5;
    localparam logic [POS_W-1:0] POS_PRESS = 5'd6;

    localparam logic [15:0] ROUTE_FIRST = 16'h0342;
    localparam logic [15:0] ROUTE_LAST = 16'h042F;
    localparam logic [15:0] RESTART_KEY = 16'h0303;
    localparam logic [15:0] CUT_BEGIN_KEY = 16'h0003;
    localparam logic [15:0] CUT_END_KEY = 16'h0027;
    localparam logic [5:0] RESTART_INDEX = 6'd32;

    // x/3 for 8-bit x as (x*171)>>9
    localparam logic [7:0] DIV3_RECIP = 8'd171;
    localparam int DIV3_SHIFT = 9;

    localparam int NUM_COMMANDS = 32;
    localparam logic [15:0] COMMAND_KEYS [NUM_COMMANDS] = '{
        16'h0006, 16'h0009, 16'h000c, 16'h000f, 16'h0012, 16'h0015, 16'h0018, 16'h001b,
        16'h001e, 16'h0021, 16'h0024, 16'h0300, 16'h0306, 16'h0309, 16'h030c, 16'h030f,
        16'h0312, 16'h0315, 16'h0318, 16'h031b, 16'h031e, 16'h0321, 16'h0324, 16'h0327,
        16'h032a, 16'h032d, 16'h0330, 16'h0333, 16'h0336, 16'h0339, 16'h033c, 16'h033f
    };

    typedef enum logic [2:0] {
        KIND_COMMAND   = 3'd0,
        KIND_ROUTE     = 3'd1,
        KIND_CUT_BEGIN = 3'd2,
        KIND_CUT_END   = 3'd3,
        KIND_ERROR     = 3'd4
    } event_kind_t;

    // what one byte does to the frame
    typedef struct packed {
        logic        err;
        logic        done;
        logic [15:0] key_code;
        logic [7:0]  press;
    } bkfd_frame_t;

    typedef struct packed {
        logic        valid;
        event_kind_t kind;
        logic [5:0]  command_index;
        logic [6:0]  column;
    } bkfd_result_t;

    typedef struct packed {
        logic       hit;
        logic [4:0] idx;
    } cmd_lookup_t;

    function automatic cmd_lookup_t lookup_command(input logic [15:0] code);
        cmd_lookup_t r;
        r = '0;
        for (int i = 0; i < NUM_COMMANDS; i++) begin
            if (code == COMMAND_KEYS[i]) begin
                r.hit = 1'b1;
                r.idx = 5'(i);
            end
        end
        return r;
    endfunction

endpackage

// ===== src/bkfd_frame_parser.sv =====
// ----------------------------------------------------------------------------
// bkfd_frame_parser: key frame byte parser
// Tracks the byte position, collects key code, length and press byte, and
// flags frame errors and completed frames.
// ----------------------------------------------------------------------------
module bkfd_frame_parser
    import bkfd_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = DEFAULT_MAX_FRAME_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        fire,
    input  logic [7:0]  rx_byte,
    output bkfd_frame_t frame
);

    localparam int LEN_W = $clog2(MAX_FRAME_BYTES + 1);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [7:0]       len_hi_reg, len_hi_next;
    logic [15:0]      key_reg, key_next;
    logic [7:0]       press_reg, press_next;

    logic [15:0]      total_len;
    logic [POS_W:0]   pos_inc;
    logic [7:0]       press_cur;

    always_comb begin
        pos_next = pos_reg;
        len_next = len_reg;
        len_hi_next = len_hi_reg;
        key_next = key_reg;
        press_next = press_reg;
        frame = '0;
        frame.key_code = key_reg;
        frame.press = press_reg;
        total_len = {len_hi_reg, rx_byte};
        pos_inc = {1'b0, pos_reg} + (POS_W+1)'(1);
        press_cur = (pos_reg == POS_PRESS) ? rx_byte : press_reg;
        case (pos_reg)
            POS_HUNT: begin
                if (rx_byte == START_BYTE) begin
                    pos_next = POS_ID;
                end else begin
                    frame.err = 1'b1;
                end
            end
            POS_ID: begin
                if (rx_byte == ID_BYTE) begin
                    pos_next = POS_KEY_HI;
                end else begin
                    pos_next = POS_HUNT;
                    frame.err = 1'b1;
                end
            end
            POS_KEY_HI: begin
                key_next = {rx_byte, 8'h00};
                pos_next = POS_KEY_LO;
            end
            POS_KEY_LO: begin
                key_next = {key_reg[15:8], rx_byte};
                pos_next = POS_LEN_HI;
            end
            POS_LEN_HI: begin
                len_hi_next = rx_byte;
                pos_next = POS_LEN_LO;
            end
            POS_LEN_LO: begin
                if (total_len > 16'(MAX_FRAME_BYTES) || total_len < 16'(MIN_FRAME_BYTES)) begin
                    pos_next = POS_HUNT;
                    frame.err = 1'b1;
                end else begin
                    len_next = total_len[LEN_W-1:0];
                    pos_next = POS_PRESS;
                end
            end
            default: begin
                press_next = press_cur;
                // last byte of the frame must be ETX
                if (pos_inc >= (POS_W+1)'(len_reg)) begin
                    pos_next = POS_HUNT;
                    frame.press = press_cur;
                    if (rx_byte != END_BYTE) begin
                        frame.err = 1'b1;
                    end else begin
                        frame.done = 1'b1;
                    end
                end else begin
                    pos_next = pos_inc[POS_W-1:0];
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_HUNT;
            len_reg <= '0;
            len_hi_reg <= '0;
            key_reg <= '0;
            press_reg <= '0;
        end else if (fire) begin
            pos_reg <= pos_next;
            len_reg <= len_next;
            len_hi_reg <= len_hi_next;
            key_reg <= key_next;
            press_reg <= press_next;
        end
    end

    a_pos_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(pos_reg) < MAX_FRAME_BYTES)
        else $error("byte position beyond maximum frame length");

    a_len_checked: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg >= POS_PRESS |-> (32'(len_reg) >= MIN_FRAME_BYTES
                                  && 32'(len_reg) <= MAX_FRAME_BYTES))
        else $error("data bytes taken with an unchecked frame length");

endmodule

// ===== src/bkfd_key_decoder.sv =====
// ----------------------------------------------------------------------------
// bkfd_key_decoder: key code to event mapping
// Maps frame errors and unknown press keys to error events, and a press frame
// to a command, routing column or cut flag update; holds both cut flags.
// ----------------------------------------------------------------------------
module bkfd_key_decoder
    import bkfd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         fire,
    input  bkfd_frame_t  frame,
    input  logic [7:0]   pressed_marker,
    output bkfd_result_t result
);

    logic        cut_begin_reg, cut_begin_next;
    logic        cut_end_reg, cut_end_next;
    cmd_lookup_t cmd;
    logic [15:0] route_off;
    logic [15:0] div_prod;
    logic [6:0]  col;
    logic        is_route;

    always_comb begin
        cut_begin_next = cut_begin_reg;
        cut_end_next = cut_end_reg;
        result = '0;
        result.kind = KIND_COMMAND;
        cmd = lookup_command(frame.key_code);
        route_off = frame.key_code - ROUTE_FIRST;
        div_prod = 16'(route_off[7:0]) * 16'(DIV3_RECIP);
        col = div_prod[DIV3_SHIFT +: 7];
        is_route = (frame.key_code >= ROUTE_FIRST) && (frame.key_code <= ROUTE_LAST);
        if (frame.err) begin
            result.valid = 1'b1;
            result.kind = KIND_ERROR;
        end else if (frame.done) begin
            if (frame.press != pressed_marker) begin
                // release frame
                cut_begin_next = 1'b0;
                cut_end_next = 1'b0;
            end else if (cmd.hit) begin
                result.valid = 1'b1;
                result.command_index = {1'b0, cmd.idx};
            end else if (frame.key_code == RESTART_KEY) begin
                result.valid = 1'b1;
                result.command_index = RESTART_INDEX;
            end else if (frame.key_code == CUT_BEGIN_KEY) begin
                cut_begin_next = 1'b1;
            end else if (frame.key_code == CUT_END_KEY) begin
                cut_end_next = 1'b1;
            end else if (is_route) begin
                result.valid = 1'b1;
                result.column = col;
                if (cut_begin_reg) begin
                    result.kind = KIND_CUT_BEGIN;
                end else if (cut_end_reg) begin
                    result.kind = KIND_CUT_END;
                end else begin
                    result.kind = KIND_ROUTE;
                end
            end else begin
                result.valid = 1'b1;
                result.kind = KIND_ERROR;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cut_begin_reg <= 1'b0;
            cut_end_reg <= 1'b0;
        end else if (fire) begin
            cut_begin_reg <= cut_begin_next;
            cut_end_reg <= cut_end_next;
        end
    end

endmodule

// ===== src/braille_key_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// braille_key_frame_decoder: key frame decoder for a braille display link
// Recognizes key frames in a received byte stream and reports key events.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_rx_byte carry received bytes, one byte per transfer.
//   m_valid/m_ready carry key events: m_event_kind, m_command_index, m_column.
//   A byte gives at most one event; most bytes inside a frame give none.
//   cfg_valid/cfg_ready/cfg_pressed_marker write the press marker byte
//   (reset value 1); cfg_ready is always high, write only while idle.
// Output: the event for a byte is registered and on the m_ side in the cycle
//   after the byte's transfer.
// Throughput: one byte per cycle while no event stalls; all parsing and key
//   lookup sits between the parser state registers and the result register.
// Reset: aresetn low for one edge returns to hunting for STX, clears both
//   cut flags and drops any pending event.
// Stall: while m_valid is high and m_ready low the result register holds
//   and s_ready is low; s_ready returns in the cycle the event is taken.
// ----------------------------------------------------------------------------
module braille_key_frame_decoder
    import bkfd_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = DEFAULT_MAX_FRAME_BYTES
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_event_kind,
    output logic [5:0] m_command_index,
    output logic [6:0] m_column,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_pressed_marker
);

    logic         fire;
    bkfd_frame_t  frame;
    bkfd_result_t result;

    logic         m_valid_reg, m_valid_next;
    event_kind_t  kind_reg;
    logic [5:0]   cmd_reg;
    logic [6:0]   col_reg;
    logic [7:0]   pressed_marker_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign fire = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    bkfd_frame_parser #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .rx_byte (s_rx_byte),
        .frame   (frame)
    );

    bkfd_key_decoder u_decoder (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .fire           (fire),
        .frame          (frame),
        .pressed_marker (pressed_marker_reg),
        .result         (result)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (fire) begin
            m_valid_next = result.valid;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            pressed_marker_reg <= PRESS_RESET;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                pressed_marker_reg <= cfg_pressed_marker;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && result.valid) begin
            kind_reg <= result.kind;
            cmd_reg <= result.command_index;
            col_reg <= result.column;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_event_kind = kind_reg;
    assign m_command_index = cmd_reg;
    assign m_column = col_reg;

    a_cmd_only_for_command: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_kind != KIND_COMMAND |-> m_command_index == 6'd0)
        else $error("command index set on a non-command event");

    a_error_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_kind == KIND_ERROR |-> m_column == 7'd0)
        else $error("column set on an error event");

    a_column_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_column <= 7'd79 && m_command_index <= RESTART_INDEX)
        else $error("event payload out of range");

    a_held_while_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready ##1 (m_valid && $stable(m_event_kind)
            && $stable(m_command_index) && $stable(m_column)))
        else $error("pending event lost or changed, or input taken during stall");

endmodule

// ===== verif/braille_key_frame_decoder_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// braille_key_frame_decoder_test: self-checking bench for the key frame decoder
// Sends received bytes as directed frames and as random frames and noise,
// tracks the frame parser and cut flags in a local predictor, and compares
// every key event against the oldest predicted one under random stalls.
// ----------------------------------------------------------------------------
module braille_key_frame_decoder_test;
    import bkfd_pkg::*;

    localparam int FRAME_MAX = DEFAULT_MAX_FRAME_BYTES;
    localparam int HOLD_CYCLES = 200;
    localparam int TIMEOUT_NS = 5_000_000;

    // key codes of the press commands in command number order
    localparam logic [15:0] PRESS_COMMAND_CODES [32] = '{
        16'h0006, 16'h0009, 16'h000c, 16'h000f, 16'h0012, 16'h0015, 16'h0018, 16'h001b,
        16'h001e, 16'h0021, 16'h0024, 16'h0300, 16'h0306, 16'h0309, 16'h030c, 16'h030f,
        16'h0312, 16'h0315, 16'h0318, 16'h031b, 16'h031e, 16'h0321, 16'h0324, 16'h0327,
        16'h032a, 16'h032d, 16'h0330, 16'h0333, 16'h0336, 16'h0339, 16'h033c, 16'h033f
    };

    typedef struct {
        event_kind_t kind;
        logic [5:0]  cmd;
        logic [6:0]  col;
    } key_event_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [2:0] m_event_kind;
    logic [5:0] m_command_index;
    logic [6:0] m_column;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_pressed_marker = 8'h00;

    // predictor state
    logic [4:0]  frame_pos = POS_HUNT;
    logic [15:0] frame_len = '0;
    logic [15:0] key_reg = '0;
    logic [7:0]  press_reg = '0;
    bit          begin_flag = 1'b0;
    bit          end_flag = 1'b0;
    logic [7:0]  marker_reg = PRESS_RESET;

    key_event_t pending_events[$];
    key_event_t seen_event;
    int         fail_count = 0;
    int         bytes_sent = 0;
    int         hold_seq = 0;
    bit         calm = 1'b0;

    braille_key_frame_decoder #(
        .MAX_FRAME_BYTES(FRAME_MAX)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_rx_byte(s_rx_byte),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_event_kind(m_event_kind),
        .m_command_index(m_command_index),
        .m_column(m_column),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_pressed_marker(cfg_pressed_marker)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic bit decode_key(output key_event_t ev);
        logic [15:0] offset;
        ev = '{kind: KIND_ERROR, cmd: 6'd0, col: 7'd0};
        // a release frame only clears the cut flags
        if (press_reg != marker_reg) begin
            begin_flag = 1'b0;
            end_flag = 1'b0;
            return 1'b0;
        end
        for (int i = 0; i < 32; i++) begin
            if (key_reg == PRESS_COMMAND_CODES[i]) begin
                ev.kind = KIND_COMMAND;
                ev.cmd = 6'(i);
                return 1'b1;
            end
        end
        if (key_reg == RESTART_KEY) begin
            ev.kind = KIND_COMMAND;
            ev.cmd = RESTART_INDEX;
            return 1'b1;
        end
        if (key_reg == CUT_BEGIN_KEY) begin
            begin_flag = 1'b1;
            return 1'b0;
        end
        if (key_reg == CUT_END_KEY) begin
            end_flag = 1'b1;
            return 1'b0;
        end
        if (key_reg >= ROUTE_FIRST && key_reg <= ROUTE_LAST) begin
            offset = key_reg - ROUTE_FIRST;
            ev.col = 7'(offset / 3);
            if (begin_flag) begin
                ev.kind = KIND_CUT_BEGIN;
            end else if (end_flag) begin
                ev.kind = KIND_CUT_END;
            end else begin
                ev.kind = KIND_ROUTE;
            end
        end
        return 1'b1;
    endfunction

    function automatic void predict_key_event(input logic [7:0] b);
        key_event_t ev;
        bit         fires;
        ev = '{kind: KIND_ERROR, cmd: 6'd0, col: 7'd0};
        fires = 1'b0;
        case (frame_pos)
            POS_HUNT: begin
                if (b == START_BYTE) begin
                    frame_pos = POS_ID;
                end else begin
                    fires = 1'b1;
                end
            end
            POS_ID: begin
                if (b == ID_BYTE) begin
                    frame_pos = POS_KEY_HI;
                end else begin
                    frame_pos = POS_HUNT;
                    fires = 1'b1;
                end
            end
            POS_KEY_HI: begin
                key_reg = {b, 8'h00};
                frame_pos = POS_KEY_LO;
            end
            POS_KEY_LO: begin
                key_reg[7:0] = b;
                frame_pos = POS_LEN_HI;
            end
            POS_LEN_HI: begin
                frame_len = {b, 8'h00};
                frame_pos = POS_LEN_LO;
            end
            POS_LEN_LO: begin
                frame_len[7:0] = b;
                if (frame_len > FRAME_MAX || frame_len < MIN_FRAME_BYTES) begin
                    frame_pos = POS_HUNT;
                    fires = 1'b1;
                end else begin
                    frame_pos = POS_PRESS;
                end
            end
            default: begin
                if (frame_pos == POS_PRESS) begin
                    press_reg = b;
                end
                if (int'(frame_pos) + 1 >= int'(frame_len)) begin
                    frame_pos = POS_HUNT;
                    if (b != END_BYTE) begin
                        fires = 1'b1;
                    end else begin
                        fires = decode_key(ev);
                    end
                end else begin
                    frame_pos = frame_pos + 5'd1;
                end
            end
        endcase
        if (fires) begin
            pending_events.push_back(ev);
        end
    endfunction

    // ------------------------------------------------------------------
    // result side: random stalls, long hold-off on request, checking
    // ------------------------------------------------------------------
    initial begin : receiver
        int seen;
        int n;
        seen = 0;
        forever begin
            @(posedge aclk);
            if (hold_seq != seen) begin
                seen = hold_seq;
                for (n = 0; n < HOLD_CYCLES; n++) begin
                    m_ready <= 1'b0;
                    @(posedge aclk);
                end
            end
            m_ready <= calm || ($urandom_range(0, 99) >= 21);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_events.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("unexpected event: kind %0d cmd %0d col %0d",
                             m_event_kind, m_command_index, m_column);
                end
            end else begin
                seen_event = pending_events.pop_front();
                if (m_event_kind !== seen_event.kind || m_command_index !== seen_event.cmd ||
                    m_column !== seen_event.col) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display({"event mismatch: expected kind %0d cmd %0d col %0d, ",
                                  "got kind %0d cmd %0d col %0d"},
                                 seen_event.kind, seen_event.cmd, seen_event.col,
                                 m_event_kind, m_command_index, m_column);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // byte side
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        if (!calm) begin
            while ($urandom_range(0, 99) < 21) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
        predict_key_event(b);
    endtask

    task automatic send_frame(input logic [15:0] key, input logic [15:0] len,
                              input logic [7:0] press, input logic [7:0] last_byte,
                              input bit stx_fill);
        logic [7:0] fill;
        send_byte(START_BYTE);
        send_byte(ID_BYTE);
        send_byte(key[15:8]);
        send_byte(key[7:0]);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        if (len >= MIN_FRAME_BYTES && len <= FRAME_MAX) begin
            for (int pos = 6; pos < int'(len); pos++) begin
                fill = 8'($urandom);
                if (stx_fill || $urandom_range(0, 7) == 0) begin
                    fill = START_BYTE;
                end
                if (pos == int'(len) - 1) begin
                    send_byte(last_byte);
                end else if (pos == 6) begin
                    send_byte(press);
                end else begin
                    send_byte(fill);
                end
            end
        end
    endtask

    // register write once no event is outstanding and the block has settled
    task automatic write_marker(input logic [7:0] value);
        s_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_pressed_marker <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        marker_reg = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 4);
        if ($urandom_range(0, 2) == 0) begin
            send_byte(START_BYTE);
        end
        repeat (n) send_byte(8'($urandom));
    endtask

    task automatic send_random_frame();
        logic [15:0] key;
        logic [15:0] len;
        logic [7:0]  press;
        logic [7:0]  last_byte;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: key = PRESS_COMMAND_CODES[$urandom_range(0, 31)];
            4:          key = RESTART_KEY;
            5:          key = CUT_BEGIN_KEY;
            6:          key = CUT_END_KEY;
            7, 8:       key = 16'($urandom_range(ROUTE_FIRST, ROUTE_LAST));
            default:    key = 16'($urandom);
        endcase
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
                0:       len = 16'($urandom_range(0, MIN_FRAME_BYTES - 1));
                1:       len = 16'(FRAME_MAX + 1);
                2:       len = 16'($urandom);
                default: len = 16'hFFFF;
            endcase
        end else if ($urandom_range(0, 3) == 0) begin
            len = 16'($urandom_range(MIN_FRAME_BYTES, FRAME_MAX));
        end else begin
            len = 16'($urandom_range(MIN_FRAME_BYTES, 10));
        end
        press = ($urandom_range(0, 3) != 0) ? marker_reg : 8'($urandom);
        last_byte = ($urandom_range(0, 9) != 0) ? END_BYTE : 8'($urandom);
        send_frame(key, len, press, last_byte, $urandom_range(0, 15) == 0);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_hunt_errors();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(END_BYTE);
        send_byte(ID_BYTE);
    endtask

    task automatic test_bad_header();
        send_byte(START_BYTE);
        send_byte(8'h4A);
        send_byte(START_BYTE);
        send_byte(START_BYTE);
        send_frame(16'h0006, 16'd6, marker_reg, END_BYTE, 1'b0);
        send_frame(16'h0006, 16'(FRAME_MAX + 1), marker_reg, END_BYTE, 1'b0);
        send_frame(16'h0006, 16'h0107, marker_reg, END_BYTE, 1'b0);
        send_frame(16'h0006, 16'hFFFF, marker_reg, END_BYTE, 1'b0);
        send_frame(16'h0006, 16'h0000, marker_reg, END_BYTE, 1'b0);
    endtask

    task automatic test_frame_end();
        // missing end byte, then start bytes inside a maximum length frame
        send_frame(16'h0006, 16'd8, marker_reg, START_BYTE, 1'b0);
        send_frame(16'h0009, 16'(FRAME_MAX), marker_reg, END_BYTE, 1'b1);
        send_frame(16'h0000, 16'd8, marker_reg, END_BYTE, 1'b0);
        send_frame(16'hFFFF, 16'd8, marker_reg, END_BYTE, 1'b0);
        send_frame(16'h0341, 16'd9, marker_reg, END_BYTE, 1'b0);
        send_frame(16'h0430, 16'd9, marker_reg, END_BYTE, 1'b0);
        // unknown key in a release frame gives nothing
        send_frame(16'hFFFF, 16'd8, ~marker_reg, END_BYTE, 1'b0);
    endtask

    task automatic test_command_table();
        // in the shortest frames the end byte doubles as the press byte
        write_marker(END_BYTE);
        for (int i = 0; i < 32; i++) begin
            send_frame(PRESS_COMMAND_CODES[i], 16'(7 + (i % 2)), marker_reg, END_BYTE, 1'b0);
        end
        send_frame(RESTART_KEY, 16'd7, marker_reg, END_BYTE, 1'b0);
        send_frame(ROUTE_FIRST, 16'd7, marker_reg, END_BYTE, 1'b0);
        send_frame(ROUTE_LAST, 16'd7, marker_reg, END_BYTE, 1'b0);
    endtask

    task automatic test_cut_flags();
        send_frame(CUT_BEGIN_KEY, 16'd8, marker_reg, END_BYTE, 1'b0);
        send_frame(16'h0345, 16'd8, marker_reg, END_BYTE, 1'b0);
        send_frame(16'h0006, 16'd8, ~marker_reg, END_BYTE, 1'b0);
        send_frame(16'h0346, 16'd8, marker_reg, END_BYTE, 1'b0);
        send_frame(CUT_END_KEY, 16'd8, marker_reg, END_BYTE, 1'b0);
        send_frame(16'h0400, 16'd8, marker_reg, END_BYTE, 1'b0);
        send_frame(CUT_BEGIN_KEY, 16'd8, marker_reg, END_BYTE, 1'b0);
        send_frame(16'h042F, 16'd8, marker_reg, END_BYTE, 1'b0);
        send_frame(CUT_END_KEY, 16'd8, ~marker_reg, END_BYTE, 1'b0);
        send_frame(16'h0342, 16'd8, marker_reg, END_BYTE, 1'b0);
    endtask

    task automatic test_backpressure();
        // receiver stops taking events while the sender keeps offering bytes
        calm = 1'b1;
        hold_seq++;
        repeat (30) send_byte(8'($urandom_range(START_BYTE + 1, 8'hFF)));
        calm = 1'b0;
    endtask

    task automatic test_random_phase(input logic [7:0] marker, input int budget,
                                     input bit quiet);
        int start;
        write_marker(marker);
        calm = quiet;
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            if ($urandom_range(0, 9) < 8) begin
                send_random_frame();
            end else begin
                send_noise();
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_hunt_errors();
        test_bad_header();
        test_frame_end();
        test_command_table();
        test_cut_flags();
        test_backpressure();
        test_random_phase(8'h00, 180, 1'b0);
        test_random_phase(8'hFF, 180, 1'b1);
        test_random_phase(8'($urandom), 180, 1'b0);
        test_random_phase(PRESS_RESET, 180, 1'b0);
        s_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && pending_events.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule
